>>> design/gdc_pkg.sv
// gdc_pkg: shared constants of the gesture direction classifier
`timescale 1ns / 1ps

package gdc_pkg;

    localparam int CHAN_W  = 8;
    localparam int CODE_W  = 3;
    localparam int REQ_W   = 2;
    localparam int ADDR_W  = 4;
    localparam int DATA_W  = 32;

    localparam logic [CHAN_W-1:0] LOW_LIMIT_RESET  = 8'd10;
    localparam logic [CHAN_W-1:0] HIGH_LIMIT_RESET = 8'd240;
    localparam logic [CHAN_W-1:0] THRESHOLD_RESET  = 8'd10;

    localparam logic [6:0] RATIO_SCALE = 7'd100;

    // request types
    localparam logic [REQ_W-1:0] REQ_SAMPLE      = 2'd0;
    localparam logic [REQ_W-1:0] REQ_NO_IRQ      = 2'd1;
    localparam logic [REQ_W-1:0] REQ_FIFO_INVAL  = 2'd2;
    localparam logic [REQ_W-1:0] REQ_FIFO_EMPTY  = 2'd3;

    // gesture codes
    localparam logic [CODE_W-1:0] CODE_NONE    = 3'd0;
    localparam logic [CODE_W-1:0] CODE_UP      = 3'd1;
    localparam logic [CODE_W-1:0] CODE_DOWN    = 3'd2;
    localparam logic [CODE_W-1:0] CODE_LEFT    = 3'd3;
    localparam logic [CODE_W-1:0] CODE_RIGHT   = 3'd4;
    localparam logic [CODE_W-1:0] CODE_INVALID = 3'd5;
    localparam logic [CODE_W-1:0] CODE_EMPTY   = 3'd6;

    // register indexes
    localparam logic [1:0] REG_LOW_LIMIT  = 2'd0;
    localparam logic [1:0] REG_HIGH_LIMIT = 2'd1;
    localparam logic [1:0] REG_THRESHOLD  = 2'd2;

    typedef logic signed [7:0] ratio_t;

endpackage

>>> design/gesture_direction_classifier.sv
// gesture_direction_classifier: sample qualification, shared ratio divider, direction decision
//
// Input channel (s_valid/s_ready) takes one word per session step: a status event
// (req_type nonzero) or a four-channel sample, the final one flagged by last_sample.
// Result channel (m_valid/m_ready) gives one gesture code per status event and per
// final sample; samples that are not final give nothing.
// Status events and final samples without two valid samples answer in the cycle after
// acceptance. A final sample with a first and a latest valid sample runs four
// ratio divisions on one shared restoring divider, each an operand load followed by
// seven quotient-bit steps; s_ready is low from acceptance until the result is
// registered. Non-final samples are taken one per cycle while the output register is free.
// The result sits in an output register; while it is not taken, s_ready stays low
// and a finished computation waits in its last step.
// Reset (aresetn low, synchronous) clears the session, empties the output register
// and loads the limit and threshold registers with 10, 240 and 10.
// The APB port holds sample_low_limit at 0x0, sample_high_limit at 0x4 and
// direction_threshold at 0x8; pready is always high.
`timescale 1ns / 1ps

module gesture_direction_classifier (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [gdc_pkg::REQ_W-1:0]     s_req_type,
    input  logic [gdc_pkg::CHAN_W-1:0]    s_chan_up,
    input  logic [gdc_pkg::CHAN_W-1:0]    s_chan_down,
    input  logic [gdc_pkg::CHAN_W-1:0]    s_chan_left,
    input  logic [gdc_pkg::CHAN_W-1:0]    s_chan_right,
    input  logic                          s_last_sample,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [gdc_pkg::CODE_W-1:0]    m_gesture_code,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [gdc_pkg::ADDR_W-1:0]    paddr,
    input  logic [gdc_pkg::DATA_W-1:0]    pwdata,
    output logic [gdc_pkg::DATA_W-1:0]    prdata,
    output logic                          pready
);

    import gdc_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_LOAD = 2'd1;
    localparam logic [1:0] ST_DIV  = 2'd2;
    localparam logic [1:0] ST_DONE = 2'd3;

    localparam logic [2:0] DIV_TOP = 3'd6;

    logic [CHAN_W-1:0] low_reg, high_reg, thr_reg;
    logic [31:0]       first_reg, first_next;
    logic [31:0]       latest_reg, latest_next;
    logic              first_seen_reg, first_seen_next;
    logic              latest_seen_reg, latest_seen_next;
    logic [1:0]        state_reg, state_next;
    logic [1:0]        pair_reg, pair_next;
    logic [2:0]        cnt_reg, cnt_next;
    logic [14:0]       rem_reg, rem_next;
    logic [8:0]        div_reg, div_next;
    logic [6:0]        quo_reg, quo_next;
    logic              neg_reg, neg_next;
    logic              zero_reg, zero_next;
    ratio_t            ratio_reg [4];
    ratio_t            ratio_next [4];
    logic              out_valid_reg, out_valid_next;
    logic [CODE_W-1:0] out_code_reg, out_code_next;

    logic              cfg_we;
    logic              accept;
    logic              out_free;
    logic              sample_ok;
    logic [31:0]       packed_in;
    logic [31:0]       pair_word;
    logic [CHAN_W-1:0] op_a, op_b, op_mag;
    logic [15:0]       trial;
    logic              ge;
    logic [6:0]        quo_final;
    ratio_t            ratio_val;
    logic signed [9:0] dud, dlr, thr_s;
    logic [CODE_W-1:0] calc_code;

    function automatic logic chan_ok(input logic [CHAN_W-1:0] v,
                                     input logic [CHAN_W-1:0] lo,
                                     input logic [CHAN_W-1:0] hi);
        return (v > lo) && (v < hi);
    endfunction

    assign pready   = 1'b1;
    assign cfg_we   = psel && penable && pwrite;
    assign out_free = !out_valid_reg || m_ready;
    assign s_ready  = (state_reg == ST_IDLE) && out_free;
    assign accept   = s_valid && s_ready;
    assign m_valid  = out_valid_reg;
    assign m_gesture_code = out_code_reg;

    always_comb begin
        unique case (paddr[3:2])
            REG_LOW_LIMIT:  prdata = {24'd0, low_reg};
            REG_HIGH_LIMIT: prdata = {24'd0, high_reg};
            REG_THRESHOLD:  prdata = {24'd0, thr_reg};
            default:        prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            low_reg  <= LOW_LIMIT_RESET;
            high_reg <= HIGH_LIMIT_RESET;
            thr_reg  <= THRESHOLD_RESET;
        end else if (cfg_we) begin
            unique case (paddr[3:2])
                REG_LOW_LIMIT:  low_reg  <= pwdata[CHAN_W-1:0];
                REG_HIGH_LIMIT: high_reg <= pwdata[CHAN_W-1:0];
                REG_THRESHOLD:  thr_reg  <= pwdata[CHAN_W-1:0];
                default: ;
            endcase
        end
    end

    assign sample_ok = chan_ok(s_chan_up, low_reg, high_reg)
                    && chan_ok(s_chan_down, low_reg, high_reg)
                    && chan_ok(s_chan_left, low_reg, high_reg)
                    && chan_ok(s_chan_right, low_reg, high_reg);
    assign packed_in = {s_chan_right, s_chan_left, s_chan_down, s_chan_up};

    // pairs 0/1 from the first sample, 2/3 from the latest
    assign pair_word = pair_reg[1] ? latest_reg : first_reg;
    assign op_a   = pair_reg[0] ? pair_word[23:16] : pair_word[7:0];
    assign op_b   = pair_reg[0] ? pair_word[31:24] : pair_word[15:8];
    assign op_mag = (op_a >= op_b) ? (op_a - op_b) : (op_b - op_a);

    // one restoring step per cycle
    assign trial     = {7'd0, div_reg} << cnt_reg;
    assign ge        = {1'b0, rem_reg} >= trial;
    assign quo_final = quo_reg | (7'(ge) << cnt_reg);
    assign ratio_val = zero_reg ? ratio_t'(0)
                     : neg_reg ? -ratio_t'({1'b0, quo_final})
                     : ratio_t'({1'b0, quo_final});

    assign dud   = 10'(ratio_reg[2]) - 10'(ratio_reg[0]);
    assign dlr   = 10'(ratio_reg[3]) - 10'(ratio_reg[1]);
    assign thr_s = signed'({2'b00, thr_reg});

    always_comb begin
        priority if (dud > dlr && dud > thr_s) begin
            calc_code = CODE_UP;
        end else if (dud > dlr && dud < -thr_s) begin
            calc_code = CODE_DOWN;
        end else if (dud < dlr && dlr > thr_s) begin
            calc_code = CODE_LEFT;
        end else if (dud < dlr && dlr < -thr_s) begin
            calc_code = CODE_RIGHT;
        end else begin
            calc_code = CODE_INVALID;
        end
    end

    always_comb begin
        first_next       = first_reg;
        latest_next      = latest_reg;
        first_seen_next  = first_seen_reg;
        latest_seen_next = latest_seen_reg;
        state_next       = state_reg;
        pair_next        = pair_reg;
        cnt_next         = cnt_reg;
        rem_next         = rem_reg;
        div_next         = div_reg;
        quo_next         = quo_reg;
        neg_next         = neg_reg;
        zero_next        = zero_reg;
        ratio_next       = ratio_reg;
        out_valid_next   = out_valid_reg && !m_ready;
        out_code_next    = out_code_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    if (s_req_type != REQ_SAMPLE) begin
                        out_valid_next   = 1'b1;
                        out_code_next    = (s_req_type == REQ_NO_IRQ) ? CODE_NONE
                                         : (s_req_type == REQ_FIFO_INVAL) ? CODE_INVALID
                                         : CODE_EMPTY;
                        first_seen_next  = 1'b0;
                        latest_seen_next = 1'b0;
                    end else begin
                        if (sample_ok) begin
                            if (!first_seen_reg) begin
                                first_next      = packed_in;
                                first_seen_next = 1'b1;
                            end else begin
                                latest_next      = packed_in;
                                latest_seen_next = 1'b1;
                            end
                        end
                        if (s_last_sample) begin
                            if (first_seen_next && latest_seen_next) begin
                                state_next = ST_LOAD;
                                pair_next  = 2'd0;
                            end else begin
                                out_valid_next   = 1'b1;
                                out_code_next    = CODE_NONE;
                                first_seen_next  = 1'b0;
                                latest_seen_next = 1'b0;
                            end
                        end
                    end
                end
            end
            ST_LOAD: begin
                rem_next   = 15'(op_mag) * 15'(RATIO_SCALE);
                div_next   = 9'(op_a) + 9'(op_b);
                neg_next   = op_a < op_b;
                zero_next  = (op_a == '0) && (op_b == '0);
                quo_next   = '0;
                cnt_next   = DIV_TOP;
                state_next = ST_DIV;
            end
            ST_DIV: begin
                rem_next = ge ? (rem_reg - trial[14:0]) : rem_reg;
                quo_next = quo_final;
                if (cnt_reg == '0) begin
                    ratio_next[pair_reg] = ratio_val;
                    if (pair_reg == 2'd3) begin
                        state_next = ST_DONE;
                    end else begin
                        pair_next  = pair_reg + 2'd1;
                        state_next = ST_LOAD;
                    end
                end else begin
                    cnt_next = cnt_reg - 3'd1;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    out_valid_next   = 1'b1;
                    out_code_next    = calc_code;
                    first_seen_next  = 1'b0;
                    latest_seen_next = 1'b0;
                    state_next       = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            first_seen_reg  <= 1'b0;
            latest_seen_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
        end else begin
            state_reg       <= state_next;
            first_seen_reg  <= first_seen_next;
            latest_seen_reg <= latest_seen_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        first_reg    <= first_next;
        latest_reg   <= latest_next;
        pair_reg     <= pair_next;
        cnt_reg      <= cnt_next;
        rem_reg      <= rem_next;
        div_reg      <= div_next;
        quo_reg      <= quo_next;
        neg_reg      <= neg_next;
        zero_reg     <= zero_next;
        ratio_reg    <= ratio_next;
        out_code_reg <= out_code_next;
    end

endmodule
